[sv/assert_macros.svh]
// assertion macros shared by the tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/nnt_pkg.sv]
// types, constants and codes of the nearest neighbour track matcher
package nnt_pkg;

    localparam int MAX_TRACKS_DEF = 32;
    localparam int COORD_W        = 14;
    localparam int ID_W           = 16;
    localparam int SQ_W           = 2 * COORD_W;
    localparam int DIST_W         = SQ_W + 1;

    localparam logic [COORD_W-1:0] MIN_Y_RST  = 14'd200;
    localparam logic [COORD_W-1:0] RADIUS_RST = 14'd400;

    localparam logic CFG_MIN_Y  = 1'b0;
    localparam logic CFG_RADIUS = 1'b1;

    localparam logic CMD_DETECT = 1'b0;
    localparam logic CMD_EOF    = 1'b1;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0] track_id;
        logic            is_new;
        logic            table_full;
    } t_out;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ID_W-1:0]    id;
    } t_track;

    localparam int TRACK_W = $bits(t_track);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_COPY
    } t_state;

endpackage

[sv/nnt_ram.sv]
// single port write, single port read memory with registered read data
module nnt_ram #(
    parameter int DEPTH = nnt_pkg::MAX_TRACKS_DEF,
    parameter int WIDTH = nnt_pkg::TRACK_W,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/nnt_dist.sv]
// squared coordinate differences of one stored track, one registered stage
module nnt_dist #(
    parameter int AW = $clog2(nnt_pkg::MAX_TRACKS_DEF)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [AW-1:0]                  i_idx,
    input  nnt_pkg::t_track                i_entry,
    input  logic [nnt_pkg::COORD_W-1:0]    i_cx,
    input  logic [nnt_pkg::COORD_W-1:0]    i_cy,
    output logic                           o_valid,
    output logic [AW-1:0]                  o_idx,
    output logic [nnt_pkg::ID_W-1:0]       o_id,
    output logic [nnt_pkg::SQ_W-1:0]       o_sqx,
    output logic [nnt_pkg::SQ_W-1:0]       o_sqy
);

    logic [nnt_pkg::COORD_W-1:0] dx;
    logic [nnt_pkg::COORD_W-1:0] dy;
    logic                        r_valid;
    logic [AW-1:0]               r_idx;
    logic [nnt_pkg::ID_W-1:0]    r_id;
    logic [nnt_pkg::SQ_W-1:0]    r_sqx;
    logic [nnt_pkg::SQ_W-1:0]    r_sqy;

    assign dx = (i_entry.x > i_cx) ? (i_entry.x - i_cx) : (i_cx - i_entry.x);
    assign dy = (i_entry.y > i_cy) ? (i_entry.y - i_cy) : (i_cy - i_entry.y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_idx <= i_idx;
        r_id  <= i_entry.id;
        r_sqx <= nnt_pkg::SQ_W'(dx) * nnt_pkg::SQ_W'(dx);
        r_sqy <= nnt_pkg::SQ_W'(dy) * nnt_pkg::SQ_W'(dy);
    end

    assign o_valid = r_valid;
    assign o_idx   = r_idx;
    assign o_id    = r_id;
    assign o_sqx   = r_sqx;
    assign o_sqy   = r_sqy;

endmodule

[sv/nearest_neighbour_track_matcher.sv]
// top level of the nearest neighbour track matcher
// A detection scans the previous frame's table when it holds entries and goes straight
// to the decision when it is empty; the scan reads the track memory's single read port
// one entry a cycle. An ignored detection is dropped without a scan. An end-of-frame mark
// copies the entries carried into the next frame, one memory write a cycle. A result waits
// in an output register; a new transaction is taken while it waits, but the next decision
// waits while it is stalled.
`include "assert_macros.svh"

module nearest_neighbour_track_matcher #(
    parameter int MAX_TRACKS = nnt_pkg::MAX_TRACKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  nnt_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output nnt_pkg::t_out               o_out_data,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [nnt_pkg::COORD_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_TRACKS);
    localparam int CW = $clog2(MAX_TRACKS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_TRACKS);

    nnt_pkg::t_state              r_state, n_state;
    logic [nnt_pkg::COORD_W-1:0]  r_min_y, r_radius;
    logic [nnt_pkg::SQ_W-1:0]     r_limit;
    logic [nnt_pkg::COORD_W-1:0]  r_cx, n_cx, r_cy, n_cy;
    logic [CW-1:0]                r_rd_idx, n_rd_idx;
    logic                         r_v1, n_v1;
    logic [AW-1:0]                r_idx1, n_idx1;
    logic                         r_found, n_found;
    logic [nnt_pkg::DIST_W-1:0]   r_best, n_best;
    logic [AW-1:0]                r_best_ix, n_best_ix;
    logic [nnt_pkg::ID_W-1:0]     r_best_id, n_best_id;
    logic [MAX_TRACKS-1:0]        r_claimed, n_claimed;
    logic [CW-1:0]                r_pcount, n_pcount;
    logic [CW-1:0]                r_mcount, n_mcount;
    logic [CW-1:0]                r_fcount, n_fcount;
    logic [nnt_pkg::ID_W-1:0]     r_next_id, n_next_id;
    logic                         r_out_valid, n_out_valid;
    nnt_pkg::t_out                r_out, n_out;
    logic [CW-1:0]                r_src, n_src;
    logic [CW-1:0]                r_copy_n, n_copy_n;
    logic                         r_wv, n_wv;
    logic                         r_wsel, n_wsel;
    logic [AW-1:0]                r_waddr, n_waddr;

    logic                         in_accept;
    logic [CW:0]                  sum_count;
    logic [CW-1:0]                fresh_src;
    logic                         m_we, f_we;
    nnt_pkg::t_track              new_entry;
    nnt_pkg::t_track              p_rdata, m_rdata, f_rdata, p_wdata;
    logic                         d_valid;
    logic [AW-1:0]                d_idx;
    logic [nnt_pkg::ID_W-1:0]     d_id;
    logic [nnt_pkg::SQ_W-1:0]     d_sqx, d_sqy;
    logic [nnt_pkg::DIST_W-1:0]   d_sum;
    logic                         is_match;

    assign o_in_stall = (r_state != nnt_pkg::S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign sum_count  = {1'b0, r_mcount} + {1'b0, r_fcount};
    assign fresh_src  = r_src - r_mcount;
    assign new_entry  = '{x: r_cx, y: r_cy, id: (is_match ? r_best_id : r_next_id)};
    assign p_wdata    = r_wsel ? m_rdata : f_rdata;
    assign d_sum      = nnt_pkg::DIST_W'(d_sqx) + nnt_pkg::DIST_W'(d_sqy);
    assign is_match   = r_found && (r_best < nnt_pkg::DIST_W'(r_limit));

    nnt_ram #(.DEPTH(MAX_TRACKS), .WIDTH(nnt_pkg::TRACK_W), .AW(AW)) u_prev (
        .i_clk   (i_clk),
        .i_we    (r_wv),
        .i_waddr (r_waddr),
        .i_wdata (p_wdata),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (p_rdata)
    );

    nnt_ram #(.DEPTH(MAX_TRACKS), .WIDTH(nnt_pkg::TRACK_W), .AW(AW)) u_matched (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (r_mcount[AW-1:0]),
        .i_wdata (new_entry),
        .i_raddr (r_src[AW-1:0]),
        .o_rdata (m_rdata)
    );

    nnt_ram #(.DEPTH(MAX_TRACKS), .WIDTH(nnt_pkg::TRACK_W), .AW(AW)) u_fresh (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (r_fcount[AW-1:0]),
        .i_wdata (new_entry),
        .i_raddr (fresh_src[AW-1:0]),
        .o_rdata (f_rdata)
    );

    nnt_dist #(.AW(AW)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_idx   (r_idx1),
        .i_entry (p_rdata),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .o_valid (d_valid),
        .o_idx   (d_idx),
        .o_id    (d_id),
        .o_sqx   (d_sqx),
        .o_sqy   (d_sqy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nnt_pkg::S_IDLE;
            r_min_y     <= nnt_pkg::MIN_Y_RST;
            r_radius    <= nnt_pkg::RADIUS_RST;
            r_v1        <= 1'b0;
            r_found     <= 1'b0;
            r_claimed   <= '0;
            r_pcount    <= '0;
            r_mcount    <= '0;
            r_fcount    <= '0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
            r_wv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_v1        <= n_v1;
            r_found     <= n_found;
            r_claimed   <= n_claimed;
            r_pcount    <= n_pcount;
            r_mcount    <= n_mcount;
            r_fcount    <= n_fcount;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
            r_wv        <= n_wv;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nnt_pkg::CFG_MIN_Y:  r_min_y  <= i_cfg_data;
                    nnt_pkg::CFG_RADIUS: r_radius <= i_cfg_data;
                    default:             r_radius <= i_cfg_data;
                endcase
            end
        end
        r_limit   <= nnt_pkg::SQ_W'(r_radius) * nnt_pkg::SQ_W'(r_radius);
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_rd_idx  <= n_rd_idx;
        r_idx1    <= n_idx1;
        r_best    <= n_best;
        r_best_ix <= n_best_ix;
        r_best_id <= n_best_id;
        r_out     <= n_out;
        r_src     <= n_src;
        r_copy_n  <= n_copy_n;
        r_wsel    <= n_wsel;
        r_waddr   <= n_waddr;
    end

    always_comb begin
        n_state     = r_state;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_rd_idx    = r_rd_idx;
        n_v1        = 1'b0;
        n_idx1      = r_rd_idx[AW-1:0];
        n_found     = r_found;
        n_best      = r_best;
        n_best_ix   = r_best_ix;
        n_best_id   = r_best_id;
        n_claimed   = r_claimed;
        n_pcount    = r_pcount;
        n_mcount    = r_mcount;
        n_fcount    = r_fcount;
        n_next_id   = r_next_id;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_src       = r_src;
        n_copy_n    = r_copy_n;
        n_wv        = 1'b0;
        n_wsel      = r_wsel;
        n_waddr     = r_waddr;
        m_we        = 1'b0;
        f_we        = 1'b0;

        // nearest candidate tracking, lowest index kept on ties
        if (d_valid && !r_claimed[d_idx] && (!r_found || d_sum < r_best)) begin
            n_found   = 1'b1;
            n_best    = d_sum;
            n_best_ix = d_idx;
            n_best_id = d_id;
        end

        case (r_state)
            nnt_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_in_data.command == nnt_pkg::CMD_EOF) begin
                        n_src    = '0;
                        n_copy_n = (sum_count > {1'b0, MAX_C}) ? MAX_C : sum_count[CW-1:0];
                        n_state  = nnt_pkg::S_COPY;
                    end else if (i_in_data.center_y >= r_min_y) begin
                        n_cx     = i_in_data.center_x;
                        n_cy     = i_in_data.center_y;
                        n_found  = 1'b0;
                        n_rd_idx = '0;
                        n_state  = (r_pcount == '0) ? nnt_pkg::S_DECIDE : nnt_pkg::S_SCAN;
                    end
                end
            end
            nnt_pkg::S_SCAN: begin
                n_v1     = 1'b1;
                n_rd_idx = r_rd_idx + 1'b1;
                if (r_rd_idx == r_pcount - 1'b1) begin
                    n_state = nnt_pkg::S_DRAIN;
                end
            end
            nnt_pkg::S_DRAIN: begin
                if (!r_v1 && !d_valid) begin
                    n_state = nnt_pkg::S_DECIDE;
                end
            end
            nnt_pkg::S_DECIDE: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_out_valid    = 1'b1;
                    n_out.is_new   = !is_match;
                    n_out.track_id = is_match ? r_best_id : r_next_id;
                    if (is_match) begin
                        n_claimed[r_best_ix] = 1'b1;
                        n_out.table_full     = (r_mcount == MAX_C);
                        if (r_mcount != MAX_C) begin
                            m_we     = 1'b1;
                            n_mcount = r_mcount + 1'b1;
                        end
                    end else begin
                        n_next_id        = r_next_id + 1'b1;
                        n_out.table_full = (r_fcount == MAX_C);
                        if (r_fcount != MAX_C) begin
                            f_we     = 1'b1;
                            n_fcount = r_fcount + 1'b1;
                        end
                    end
                    n_state = nnt_pkg::S_IDLE;
                end
            end
            nnt_pkg::S_COPY: begin
                if (r_src != r_copy_n) begin
                    n_wv    = 1'b1;
                    n_wsel  = (r_src < r_mcount);
                    n_waddr = r_src[AW-1:0];
                    n_src   = r_src + 1'b1;
                end else if (!r_wv) begin
                    n_pcount  = r_copy_n;
                    n_mcount  = '0;
                    n_fcount  = '0;
                    n_claimed = '0;
                    n_state   = nnt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nnt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_CLK(a_dist_in_scan, d_valid |-> (r_state == nnt_pkg::S_SCAN || r_state == nnt_pkg::S_DRAIN), "distance result outside scan")
    `ASSERT_CLK(a_counts_bounded, (r_mcount <= MAX_C) && (r_fcount <= MAX_C) && (r_pcount <= MAX_C), "list count above capacity")
    `ASSERT_CLK(a_decide_gives_result, (r_state == nnt_pkg::S_DECIDE && n_state == nnt_pkg::S_IDLE) |=> o_out_valid, "decision without result")
    `ASSERT_CLK(a_copy_write_only_in_copy, r_wv |-> (r_state == nnt_pkg::S_COPY), "track table written outside frame end")
    `ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == nnt_pkg::S_IDLE && !o_out_valid), "not idle after reset")

endmodule
